@@ rtl/llc_pkg.sv @@
// Shared constants, tables and helper functions of the latitude/longitude converter.
package llc_pkg;

   localparam logic [24:0]        ANGLE_FULL    = 25'd23592960;
   localparam logic signed [25:0] POLAR_OFFSET  = 26'sd5898240;
   localparam logic [24:0]        RECIP_45      = 25'd23860929;
   localparam logic [18:0]        DIV_45        = 19'd45;
   localparam logic signed [31:0] GAIN_Q30      = 32'sd652032874;
   localparam logic signed [29:0] OUT_LIMIT     = 30'sd16776960;
   localparam int                 MAX_ITER      = 32;
   localparam logic [15:0]        RADIUS_RESET  = 16'd3960;
   localparam logic               ADDR_RADIUS   = 1'b0;

   typedef logic signed [31:0] q30_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         5'd24: val = 32'd41;
         5'd25: val = 32'd20;
         5'd26: val = 32'd10;
         5'd27: val = 32'd5;
         5'd28: val = 32'd3;
         5'd29: val = 32'd1;
         5'd30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

   // Fraction part of the binary angle for a remainder b below 45.
   function automatic logic [12:0] frac_step(input logic [5:0] b);
      logic [12:0] base;
      base = 13'(b) * 13'd182;
      if (b >= 6'd34) begin
         base = base + 13'd2;
      end else if (b >= 6'd12) begin
         base = base + 13'd1;
      end
      return base;
   endfunction

   function automatic logic signed [24:0] sat_coord(input logic signed [29:0] v);
      logic signed [24:0] res;
      if (v > OUT_LIMIT) begin
         res = 25'(OUT_LIMIT);
      end else if (v < -OUT_LIMIT) begin
         res = 25'(-OUT_LIMIT);
      end else begin
         res = v[24:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/llc_angle_prep.sv @@
// Angle reduction from Q.16 degrees to a folded 32-bit binary angle, four stages.
module llc_angle_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [25:0] angle_in,
   output logic               out_valid,
   output llc_pkg::q30_type   angle_out,
   output logic               flip_out
);
   import llc_pkg::*;

   logic [3:0]  valid_ff;
   logic [24:0] r1_ff, r2_ff;
   logic [18:0] q2_ff, quo3_ff;
   logic [5:0]  rem3_ff;
   logic [31:0] ang4_ff;
   logic        flip4_ff;

   logic [25:0] wrap_in;
   logic [24:0] r1_in;
   logic [49:0] prod_in;
   logic [25:0] rem_wide;
   logic [6:0]  rem_in;
   logic [18:0] quo_in;
   logic [5:0]  b_in;
   logic [32:0] p_sum;
   logic [31:0] p_in;
   logic        flip_in;

   always_comb begin
      wrap_in  = 26'(angle_in) + {1'b0, ANGLE_FULL};
      r1_in    = angle_in[25] ? wrap_in[24:0] : angle_in[24:0];
      prod_in  = 50'(r1_ff) * 50'(RECIP_45);
      rem_wide = {1'b0, r2_ff} - 26'(q2_ff * DIV_45);
      rem_in   = rem_wide[6:0];
      if (rem_in >= 7'd45) begin
         quo_in = q2_ff + 19'd1;
         b_in   = 6'(rem_in - 7'd45);
      end else begin
         quo_in = q2_ff;
         b_in   = rem_in[5:0];
      end
      p_sum   = {1'b0, quo3_ff, 13'b0} + 33'(frac_step(rem3_ff));
      flip_in = p_sum[31] ^ p_sum[30];
      p_in    = {p_sum[31] ^ flip_in, p_sum[30:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff    <= r1_in;
         r2_ff    <= r1_ff;
         q2_ff    <= prod_in[48:30];
         quo3_ff  <= quo_in;
         rem3_ff  <= b_in;
         ang4_ff  <= p_in;
         flip4_ff <= flip_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign angle_out = ang4_ff;
   assign flip_out  = flip4_ff;

endmodule

@@ rtl/llc_cordic.sv @@
// Unrolled rotation-mode CORDIC, one iteration per stage, with a final sign stage.
module llc_cordic #(
   parameter int ITERATIONS = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  llc_pkg::q30_type angle_in,
   input  logic             flip_in,
   output logic             out_valid,
   output llc_pkg::q30_type cos_out,
   output llc_pkg::q30_type sin_out
);
   import llc_pkg::*;

   localparam int NUM = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;

   q30_type        x_ff [NUM];
   q30_type        y_ff [NUM];
   q30_type        a_ff [NUM];
   logic [NUM-1:0] f_ff;
   logic [NUM-1:0] v_ff;
   q30_type        cos_ff, sin_ff;
   logic           vout_ff;

   for (genvar k = 0; k < NUM; k++) begin : g_iter
      q30_type xp, yp, ap;
      logic    fp, vp;
      if (k == 0) begin : g_first
         assign xp = GAIN_Q30;
         assign yp = '0;
         assign ap = angle_in;
         assign fp = flip_in;
         assign vp = in_valid;
      end else begin : g_next
         assign xp = x_ff[k-1];
         assign yp = y_ff[k-1];
         assign ap = a_ff[k-1];
         assign fp = f_ff[k-1];
         assign vp = v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!ap[31]) begin
               x_ff[k] <= xp - (yp >>> k);
               y_ff[k] <= yp + (xp >>> k);
               a_ff[k] <= ap - q30_type'(atan_entry(5'(k)));
            end else begin
               x_ff[k] <= xp + (yp >>> k);
               y_ff[k] <= yp - (xp >>> k);
               a_ff[k] <= ap + q30_type'(atan_entry(5'(k)));
            end
            f_ff[k] <= fp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= v_ff[NUM-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= f_ff[NUM-1] ? -x_ff[NUM-1] : x_ff[NUM-1];
         sin_ff <= f_ff[NUM-1] ? -y_ff[NUM-1] : y_ff[NUM-1];
      end
   end

   assign out_valid = vout_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;

endmodule

@@ rtl/llc_scale.sv @@
// Products, radius scaling, rounding and saturation of the coordinates, four stages.
module llc_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  llc_pkg::q30_type   sin_polar,
   input  llc_pkg::q30_type   cos_polar,
   input  llc_pkg::q30_type   sin_lon,
   input  llc_pkg::q30_type   cos_lon,
   input  logic [15:0]        radius,
   output logic               out_valid,
   output logic signed [24:0] coord_x,
   output logic signed [24:0] coord_y,
   output logic signed [24:0] coord_z
);
   import llc_pkg::*;

   logic [3:0]         valid_ff;
   logic signed [63:0] px_ff, py_ff;
   logic signed [48:0] pz_ff;
   logic signed [33:0] tx_ff, ty_ff;
   logic signed [24:0] zb_ff, zc_ff, zd_ff;
   logic signed [50:0] sx_ff, sy_ff;
   logic signed [24:0] xd_ff, yd_ff;

   logic signed [16:0] rad_s;
   logic signed [63:0] px_rnd, py_rnd;
   logic signed [48:0] pz_rnd;
   logic signed [50:0] sx_rnd, sy_rnd;

   always_comb begin
      rad_s  = $signed({1'b0, radius});
      px_rnd = (px_ff + 64'sd536870912) >>> 30;
      py_rnd = (py_ff + 64'sd536870912) >>> 30;
      pz_rnd = (pz_ff + 49'sd2097152) >>> 22;
      sx_rnd = (sx_ff + 51'sd2097152) >>> 22;
      sy_rnd = (sy_ff + 51'sd2097152) >>> 22;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= 64'(sin_polar) * 64'(cos_lon);
         py_ff <= 64'(sin_polar) * 64'(sin_lon);
         pz_ff <= 49'(cos_polar) * 49'(rad_s);
         tx_ff <= px_rnd[33:0];
         ty_ff <= py_rnd[33:0];
         zb_ff <= sat_coord(pz_rnd[29:0]);
         sx_ff <= 51'(tx_ff) * 51'(rad_s);
         sy_ff <= 51'(ty_ff) * 51'(rad_s);
         zc_ff <= zb_ff;
         xd_ff <= sat_coord(sx_rnd[29:0]);
         yd_ff <= sat_coord(sy_rnd[29:0]);
         zd_ff <= zc_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign coord_x   = xd_ff;
   assign coord_y   = yd_ff;
   assign coord_z   = zd_ff;

endmodule

@@ rtl/latlon_to_cartesian_unit.sv @@
// Top level of the latitude/longitude to cartesian converter.
// Converts one latitude/longitude word per cycle, while the output does not stall, into x, y
// and z on a sphere whose radius in whole miles is held in the register at address 0 (reset
// value 3960). A word passes from acceptance to rsp_tvalid through four stages of angle
// reduction, one stage per CORDIC iteration plus a sign stage, four stages of multiplication
// and rounding, and the output register. Iterations beyond 32 count as 32.
// When the output stalls, a skid register catches the last word and the pipeline then holds.
module latlon_to_cartesian_unit #(
   parameter int CORDIC_ITERATIONS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // latitude_deg [24:0], longitude_deg [49:25], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // coord_x [24:0], coord_y [49:25], coord_z [74:50], pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import llc_pkg::*;

   logic [15:0]        radius_ff;
   logic               skid_valid_ff, out_valid_ff;
   logic [74:0]        skid_data_ff, out_data_ff;

   logic               en;
   logic signed [24:0] lat, lon;
   logic signed [25:0] polar, lon_ext;
   logic               pol_valid;
   q30_type            pol_angle, lon_angle;
   logic               pol_flip, lon_flip;
   logic               cor_valid;
   q30_type            cos_pol, sin_pol, cos_lon, sin_lon;
   logic               sc_valid;
   logic signed [24:0] cx, cy, cz;
   logic [74:0]        sc_data;
   logic               push, out_free;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign lat        = req_tdata[24:0];
   assign lon        = req_tdata[49:25];
   assign polar      = POLAR_OFFSET - 26'(lat);
   assign lon_ext    = 26'(lon);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == ADDR_RADIUS) begin
         radius_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ADDR_RADIUS) ? {16'b0, radius_ff} : 32'b0;

   llc_angle_prep u_prep_pol (
      .clock, .reset, .en,
      .in_valid (req_tvalid),
      .angle_in (polar),
      .out_valid(pol_valid),
      .angle_out(pol_angle),
      .flip_out (pol_flip)
   );

   llc_angle_prep u_prep_lon (
      .clock, .reset, .en,
      .in_valid (req_tvalid),
      .angle_in (lon_ext),
      .out_valid(),
      .angle_out(lon_angle),
      .flip_out (lon_flip)
   );

   llc_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_pol (
      .clock, .reset, .en,
      .in_valid (pol_valid),
      .angle_in (pol_angle),
      .flip_in  (pol_flip),
      .out_valid(cor_valid),
      .cos_out  (cos_pol),
      .sin_out  (sin_pol)
   );

   llc_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_lon (
      .clock, .reset, .en,
      .in_valid (pol_valid),
      .angle_in (lon_angle),
      .flip_in  (lon_flip),
      .out_valid(),
      .cos_out  (cos_lon),
      .sin_out  (sin_lon)
   );

   llc_scale u_scale (
      .clock, .reset, .en,
      .in_valid (cor_valid),
      .sin_polar(sin_pol),
      .cos_polar(cos_pol),
      .sin_lon  (sin_lon),
      .cos_lon  (cos_lon),
      .radius   (radius_ff),
      .out_valid(sc_valid),
      .coord_x  (cx),
      .coord_y  (cy),
      .coord_z  (cz)
   );

   assign sc_data  = {cz, cy, cx};
   assign push     = en && sc_valid;
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : sc_data;
      end else if (push) begin
         skid_data_ff <= sc_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_data_ff};

endmodule

@@ rtl/llc_checker.sv @@
// Port-level checks of the converter and their binding to the top level.
module llc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind latlon_to_cartesian_unit llc_checker u_llc_checker (.*);
